### design/pfdc_pkg.sv
// Package for the filtered-derivative PID controller with output clamp.
// Holds widths, register indexes, reset values and saturation helpers.
// No dependencies.
package pfdc_pkg;

  localparam int SIGNAL_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int GAIN_BITS     = 32;
  localparam int COEF_BITS     = 18;
  localparam int LIMIT_BITS    = 17;
  localparam int ACC_BITS      = 48;
  localparam int WIDE_BITS     = 72;
  localparam int APB_DATA_BITS = 32;
  localparam int ADDR_BITS     = 5;
  localparam int REG_IDX_BITS  = ADDR_BITS - 2;
  localparam int OUT_DATA_BITS = ((LIMIT_BITS + 7) / 8) * 8;

  localparam logic [REG_IDX_BITS-1:0] REG_PROP   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_INTEG  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DERIV  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_FILTER = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN    = 3'd5;

  localparam logic signed [LIMIT_BITS-1:0] OUT_MAX_RESET = 17'sd65535;
  localparam logic signed [LIMIT_BITS-1:0] OUT_MIN_RESET = 17'sd0;

  localparam logic signed [WIDE_BITS-1:0] PROD_LIM =
    {{(WIDE_BITS - 62){1'b0}}, 1'b1, 61'b0};
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

  // Products are limited to plus or minus two to the 61st.
  function automatic logic signed [WIDE_BITS-1:0] sat_prod(
    input logic signed [WIDE_BITS-1:0] p
  );
    logic signed [WIDE_BITS-1:0] r;
    if (p > PROD_LIM) begin
      r = PROD_LIM;
    end else if (p < -PROD_LIM) begin
      r = -PROD_LIM;
    end else begin
      r = p;
    end
    return r;
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_acc(
    input logic signed [WIDE_BITS-1:0] x
  );
    logic signed [ACC_BITS-1:0] r;
    if (x > WIDE_BITS'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (x < WIDE_BITS'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = x[ACC_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### design/pid_filtered_derivative_clamp.sv
// PID controller with trapezoid integrator, filtered derivative on the
// measurement, output clamp and clamping anti-windup.
// Depends on pfdc_pkg.
// An input transfer is captured in the input stage, and its result is registered in the output stage.
// Throughput: one item per cycle while the output is not stalled; the derivative feedback multiply
// and the clamp close a loop through the state registers.
// Reset is synchronous and active high: it empties both stages, clears the
// controller state and returns the gains to zero and the limits to 65535 and 0.
module pid_filtered_derivative_clamp
  import pfdc_pkg::*;
#(
  parameter int SIGNAL_BITS = SIGNAL_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ADDR_BITS-1:0]                   paddr,
  input  logic [APB_DATA_BITS-1:0]               pwdata,
  output logic [APB_DATA_BITS-1:0]               prdata,
  output logic                                   pready,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: target, measured, zero fill.
  input  logic [((2*SIGNAL_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0: drive, zero fill.
  output logic [OUT_DATA_BITS-1:0]               m_axis_tdata,
  // Fields from bit 0: windup.
  output logic                                   m_axis_tuser
);

  localparam int EB  = SIGNAL_BITS + 1;
  localparam int SB2 = SIGNAL_BITS + 2;
  localparam int PW  = GAIN_BITS + EB;
  localparam int IW  = GAIN_BITS + SB2;
  localparam int FW  = COEF_BITS + ACC_BITS;

  logic signed [GAIN_BITS-1:0]   prop_gain;
  logic signed [GAIN_BITS-1:0]   integ_gain;
  logic signed [GAIN_BITS-1:0]   deriv_gain;
  logic signed [COEF_BITS-1:0]   filter_coef;
  logic signed [LIMIT_BITS-1:0]  out_max;
  logic signed [LIMIT_BITS-1:0]  out_min;

  logic signed [ACC_BITS-1:0]    integ_acc;
  logic signed [ACC_BITS-1:0]    deriv_acc;
  logic signed [EB-1:0]          last_error;
  logic signed [SIGNAL_BITS-1:0] last_measured;

  logic                          in_valid;
  logic signed [SIGNAL_BITS-1:0] target_q;
  logic signed [SIGNAL_BITS-1:0] measured_q;
  logic                          out_valid;
  logic [LIMIT_BITS-1:0]         drive_q;
  logic                          windup_q;

  logic                          cfg_write;
  logic [REG_IDX_BITS-1:0]       reg_idx;
  logic                          advance;
  logic                          fire;

  logic signed [EB-1:0]          err;
  logic signed [SB2-1:0]         err_sum;
  logic signed [EB-1:0]          meas_diff;
  logic signed [PW-1:0]          p_prod;
  logic signed [IW-1:0]          i_prod;
  logic signed [PW-1:0]          d_prod;
  logic signed [FW-1:0]          f_prod;
  logic signed [WIDE_BITS-1:0]   p_term;
  logic signed [WIDE_BITS-1:0]   integ_raw;
  logic signed [WIDE_BITS-1:0]   deriv_raw;
  logic signed [WIDE_BITS-1:0]   feedback;
  logic signed [ACC_BITS-1:0]    integ_new;
  logic signed [ACC_BITS-1:0]    deriv_next;
  logic signed [WIDE_BITS-1:0]   sum;
  logic signed [WIDE_BITS-1:0]   drive_full;
  logic                          above;
  logic                          below;
  logic [LIMIT_BITS-1:0]         drive_next;
  logic                          windup_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[ADDR_BITS-1:2];

  always_comb begin
    case (reg_idx)
      REG_PROP:   prdata = APB_DATA_BITS'(prop_gain);
      REG_INTEG:  prdata = APB_DATA_BITS'(integ_gain);
      REG_DERIV:  prdata = APB_DATA_BITS'(deriv_gain);
      REG_FILTER: prdata = APB_DATA_BITS'(filter_coef);
      REG_MAX:    prdata = APB_DATA_BITS'(out_max);
      REG_MIN:    prdata = APB_DATA_BITS'(out_min);
      default:    prdata = '0;
    endcase
  end

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;

  assign err       = EB'(target_q) - EB'(measured_q);
  assign err_sum   = SB2'(err) + SB2'(last_error);
  assign meas_diff = EB'(measured_q) - EB'(last_measured);

  assign p_prod = prop_gain * err;
  assign i_prod = integ_gain * err_sum;
  assign d_prod = deriv_gain * meas_diff;
  assign f_prod = filter_coef * deriv_acc;

  assign p_term     = sat_prod(WIDE_BITS'(p_prod));
  assign integ_raw  = WIDE_BITS'(integ_acc) + sat_prod(WIDE_BITS'(i_prod));
  assign integ_new  = sat_acc(integ_raw);
  assign feedback   = WIDE_BITS'(f_prod >>> FRAC_BITS);
  assign deriv_raw  = -sat_prod(WIDE_BITS'(d_prod)) - feedback;
  assign deriv_next = sat_acc(deriv_raw);

  assign sum        = p_term + WIDE_BITS'(integ_new) + WIDE_BITS'(deriv_next);
  assign drive_full = sum >>> FRAC_BITS;
  assign above      = drive_full > WIDE_BITS'(out_max);
  assign below      = drive_full < WIDE_BITS'(out_min);

  always_comb begin
    if (above) begin
      drive_next  = out_max;
      windup_next = err > EB'(0);
    end else if (below) begin
      drive_next  = out_min;
      windup_next = err < EB'(0);
    end else begin
      drive_next  = drive_full[LIMIT_BITS-1:0];
      windup_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      filter_coef   <= '0;
      out_max       <= OUT_MAX_RESET;
      out_min       <= OUT_MIN_RESET;
      integ_acc     <= '0;
      deriv_acc     <= '0;
      last_error    <= '0;
      last_measured <= '0;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_idx)
          REG_PROP:   prop_gain   <= pwdata;
          REG_INTEG:  integ_gain  <= pwdata;
          REG_DERIV:  deriv_gain  <= pwdata;
          REG_FILTER: filter_coef <= pwdata[COEF_BITS-1:0];
          REG_MAX:    out_max     <= pwdata[LIMIT_BITS-1:0];
          REG_MIN:    out_min     <= pwdata[LIMIT_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        if (!windup_next) begin
          integ_acc <= integ_new;
        end
        deriv_acc     <= deriv_next;
        last_error    <= err;
        last_measured <= measured_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      target_q   <= s_axis_tdata[SIGNAL_BITS-1:0];
      measured_q <= s_axis_tdata[2*SIGNAL_BITS-1:SIGNAL_BITS];
    end
    if (fire) begin
      drive_q  <= drive_next;
      windup_q <= windup_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_BITS'(drive_q);
  assign m_axis_tuser  = windup_q;

endmodule

### design/pfdc_checker.sv
// Port-level checks for the filtered-derivative PID controller, and the
// bind statement that attaches them to the top level.
// Depends on pfdc_pkg and pid_filtered_derivative_clamp.
module pfdc_checker
  import pfdc_pkg::*;
(
  input logic                               clk,
  input logic                               rst,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [ADDR_BITS-1:0]               paddr,
  input logic [APB_DATA_BITS-1:0]           pwdata,
  input logic [APB_DATA_BITS-1:0]           prdata,
  input logic                               pready,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [OUT_DATA_BITS-1:0]           m_axis_tdata,
  input logic                               m_axis_tuser
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A taken result frees room for a new input in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side drains");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_BITS-1:LIMIT_BITS] == '0)
    else $error("fill bits of result data not zero");

  // A full-width gain reads back exactly what was written.
  assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready &&
     (paddr[ADDR_BITS-1:2] == REG_PROP || paddr[ADDR_BITS-1:2] == REG_INTEG ||
      paddr[ADDR_BITS-1:2] == REG_DERIV))
    ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata == $past(pwdata))
    else $error("gain register read back differs from write");

endmodule

bind pid_filtered_derivative_clamp pfdc_checker u_pfdc_checker (.*);
